[hw/rtl/tcf_pkg.sv]
package tcf_pkg;

    localparam int ID_W    = 32;
    localparam int STAMP_W = 32;

    // opcode field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // preference field, two's complement; 2'b10 has no meaning
    localparam logic [1:0] PREF_ANY = 2'b00;
    localparam logic [1:0] PREF_A   = 2'b01;
    localparam logic [1:0] PREF_B   = 2'b11;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } t_q_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_sts;

endpackage

[hw/rtl/tcf_ram.sv]
module tcf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tcf_queue.sv]
module tcf_queue #(
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcf_pkg::t_q_ctl                   i_ctl,
    input  logic [tcf_pkg::ID_W-1:0]          i_wr_id,
    input  logic [tcf_pkg::STAMP_W-1:0]       i_wr_stamp,
    output tcf_pkg::t_q_sts                   o_sts,
    output logic [tcf_pkg::ID_W-1:0]          o_rd_id,
    output logic [tcf_pkg::STAMP_W-1:0]       o_rd_stamp
);

    import tcf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = ID_W + STAMP_W;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] rdata;

    // pointers wrap at DEPTH, which need not be a power of two
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    tcf_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_tail),
        .i_wdata ({i_wr_id, i_wr_stamp}),
        .i_re    (i_ctl.rd),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_rd_id     = rdata[DW-1 -: ID_W];
    assign o_rd_stamp  = rdata[STAMP_W-1:0];

endmodule

[hw/rtl/two_class_fifo_oldest_dequeue_top.sv]
// Insert: the word is written to its class RAM at the accept edge.
// Remove: the accept edge reads both head entries; in S_READ the block picks
//   the class and loads the output register once that is free. Input stalls
//   in S_READ, so a remove is finished before the next word is taken.
// Synchronous active-low reset clears pointers, counts, arrival counter and
//   control; RAM contents are left as they are and need no clearing pass.
module two_class_fifo_oldest_dequeue_top #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_entry_id,
    input  logic signed [1:0]  i_preference,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_removed_id
);

    import tcf_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_pref, n_pref;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic [STAMP_W-1:0] r_arrival, n_arrival;

    t_q_ctl            ctl_a, ctl_b;
    t_q_sts            sts_a, sts_b;
    logic [ID_W-1:0]   rd_id_a, rd_id_b;
    logic [STAMP_W-1:0] rd_stamp_a, rd_stamp_b;

    logic              in_acc;
    logic              is_ins;
    logic              positive;
    logic              out_free;
    logic [STAMP_W-1:0] stamp_diff;
    logic              pick_a, pick_b;
    logic              load;

    assign o_in_stall = (r_state == S_READ);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_ins     = (i_opcode == OP_INSERT);
    assign positive   = (i_entry_id > 32'sd0);

    // Output register frees up when empty or being taken this edge.
    assign out_free   = !r_out_valid || !i_out_stall;

    // Wrap-safe age: head A is older when (stamp A - stamp B) is negative.
    assign stamp_diff = rd_stamp_a - rd_stamp_b;

    // Class choice, from head data read on the accept edge. Counts cannot
    // move while in S_READ since input is stalled.
    always_comb begin
        pick_a = 1'b0;
        pick_b = 1'b0;
        case (r_pref)
            PREF_ANY: begin
                if (!sts_a.empty && !sts_b.empty) begin
                    pick_a = stamp_diff[STAMP_W-1];
                    pick_b = !stamp_diff[STAMP_W-1];
                end else begin
                    pick_a = !sts_a.empty;
                    pick_b = sts_a.empty && !sts_b.empty;
                end
            end
            PREF_A: pick_a = !sts_a.empty;
            PREF_B: pick_b = !sts_b.empty;
            default: begin
                // meaningless code: request dropped
                pick_a = 1'b0;
                pick_b = 1'b0;
            end
        endcase
    end

    assign load = (r_state == S_READ) && (pick_a || pick_b) && out_free;

    always_comb begin
        // full queue drops the insert, stamp stays put
        ctl_a.push = in_acc && is_ins && positive && !sts_a.full;
        ctl_b.push = in_acc && is_ins && !positive && !sts_b.full;
        ctl_a.rd   = in_acc && !is_ins;
        ctl_b.rd   = in_acc && !is_ins;
        ctl_a.pop  = load && pick_a;
        ctl_b.pop  = load && pick_b;
    end

    always_comb begin
        n_state     = r_state;
        n_pref      = r_pref;
        n_out_valid = r_out_valid;
        n_out_id    = r_out_id;
        n_arrival   = r_arrival;
        if (ctl_a.push || ctl_b.push) begin
            n_arrival = r_arrival + 1'b1;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc && !is_ins) begin
                    n_pref  = i_preference;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!(pick_a || pick_b)) begin
                    n_state = S_IDLE;         // nothing to remove
                end else if (load) begin
                    n_out_valid = 1'b1;
                    n_out_id    = pick_a ? rd_id_a : rd_id_b;
                    n_state     = S_IDLE;
                end
                // else wait for the output register
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_arrival   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_arrival   <= n_arrival;
        end
        r_pref   <= n_pref;
        r_out_id <= n_out_id;
    end

    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_a),
        .i_wr_id    (i_entry_id),
        .i_wr_stamp (r_arrival),
        .o_sts      (sts_a),
        .o_rd_id    (rd_id_a),
        .o_rd_stamp (rd_stamp_a)
    );

    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_b),
        .i_wr_id    (i_entry_id),
        .i_wr_stamp (r_arrival),
        .o_sts      (sts_b),
        .o_rd_id    (rd_id_b),
        .o_rd_stamp (rd_stamp_b)
    );

    assign o_out_valid  = r_out_valid;
    assign o_removed_id = r_out_id;

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl_a.pop |-> !sts_a.empty) and (ctl_b.pop |-> !sts_b.empty))
        else $error("pop from empty queue");

    // a pending word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !(r_out_valid && i_out_stall))
        else $error("output word overwritten");

    // stamp advances by one per stored entry
    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl_a.push || ctl_b.push) |=> (r_arrival == $past(r_arrival) + 1'b1))
        else $error("arrival counter slip");

    // one remove in flight: queues never pop while a new word is taken
    a_pop_not_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl_a.pop || ctl_b.pop) |-> !in_acc)
        else $error("pop overlaps accept");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import tcf_pkg::*;

    localparam int QUEUE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1200;
    localparam int DRAIN_WORDS = 8;      // settle time after the last removal
    localparam int HOLD_OFF = 500;       // long output stall, to back the block up

    // The one preference code with no meaning; the block must ignore it
    localparam logic [1:0] PREF_UNUSED = 2'b10;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,    // predictor decides
        CHK_NONE,     // no removal expected
        CHK_ID        // removal of the id typed in the row
    } t_chk;

    // Entry class; CLS_NONE also means "no class constraint" when picking ids
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_A,
        CLS_B
    } t_cls;

    typedef struct packed {
        logic               op;
        logic signed [31:0] id;
        logic [1:0]         pref;
        t_chk               chk;
        logic signed [31:0] want;
    } t_row;

    // One queued entry of the shelter: id plus arrival stamp
    typedef struct packed {
        logic signed [31:0] id;
        logic [31:0]        stamp;
    } t_slot;

    localparam int N_DIR = 21;

    // Directed part: empty removes, id extremes in both classes, the unused
    // preference code, oldest-first across classes, single-class any-removes.
    localparam t_row DIR_ROWS [N_DIR] = '{
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_NONE,  32'sd0},
        '{OP_REMOVE, -32'sd1,           PREF_A,      CHK_NONE,  32'sd0},
        '{OP_REMOVE, 32'sh80000000,     PREF_B,      CHK_NONE,  32'sd0},
        '{OP_INSERT, 32'sh7fffffff,     PREF_ANY,    CHK_MODEL, 32'sd0},
        '{OP_INSERT, 32'sh80000000,     PREF_UNUSED, CHK_MODEL, 32'sd0},
        '{OP_INSERT, 32'sd0,            PREF_B,      CHK_MODEL, 32'sd0},
        '{OP_INSERT, 32'sd1,            PREF_A,      CHK_MODEL, 32'sd0},
        '{OP_INSERT, -32'sd1,           PREF_ANY,    CHK_MODEL, 32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_UNUSED, CHK_NONE,  32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_ID,    32'sh7fffffff},
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_ID,    32'sh80000000},
        '{OP_REMOVE, 32'sd0,            PREF_B,      CHK_ID,    32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_A,      CHK_ID,    32'sd1},
        '{OP_REMOVE, 32'sd0,            PREF_A,      CHK_NONE,  32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_ID,    -32'sd1},
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_NONE,  32'sd0},
        '{OP_INSERT, 32'sd2,            PREF_ANY,    CHK_MODEL, 32'sd0},
        '{OP_INSERT, 32'sd3,            PREF_ANY,    CHK_MODEL, 32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_B,      CHK_NONE,  32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_ANY,    CHK_MODEL, 32'sd0},
        '{OP_REMOVE, 32'sd0,            PREF_A,      CHK_MODEL, 32'sd0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_opcode;
    logic signed [31:0] i_entry_id;
    logic signed [1:0]  i_preference;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_removed_id;

    // Predictor state: the two class queues and the next arrival stamp
    t_slot              class_a_q [$];
    t_slot              class_b_q [$];
    logic [31:0]        next_stamp;

    // Removed ids still owed by the block, oldest first
    logic signed [31:0] removed_ids [$];

    int                 n_err = 0;
    int                 n_cycles = 0;
    int                 n_removed = 0;
    logic               tx_fast = 1'b0;
    logic               rx_fast = 1'b0;
    logic signed [31:0] want_id;

    two_class_fifo_oldest_dequeue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_entry_id   (i_entry_id),
        .i_preference (i_preference),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_removed_id (o_removed_id)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d removals still owed", $time, removed_ids.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Shelter predictor: one accepted word in, at most one removed id out.
    function automatic void shelter_step(input logic op, input logic signed [31:0] id,
            input logic [1:0] pref, output logic hit, output logic signed [31:0] out_id);
        t_slot       head;
        logic [31:0] age_diff;
        t_cls        src;
        hit = 1'b0;
        out_id = '0;
        src = CLS_NONE;
        if (op == OP_INSERT) begin
            // positive ids are class A; zero and negative are class B.
            // a word for a full queue is dropped and takes no stamp.
            if (id > 0) begin
                if (class_a_q.size() < QUEUE_DEPTH) begin
                    class_a_q.push_back({id, next_stamp});
                    next_stamp = next_stamp + 1;
                end
            end else if (class_b_q.size() < QUEUE_DEPTH) begin
                class_b_q.push_back({id, next_stamp});
                next_stamp = next_stamp + 1;
            end
        end else begin
            case (pref)
                PREF_ANY: begin
                    if (class_a_q.size() != 0 && class_b_q.size() != 0) begin
                        // wrap-safe age: A is older when stamp_a - stamp_b < 0
                        age_diff = class_a_q[0].stamp - class_b_q[0].stamp;
                        src = age_diff[31] ? CLS_A : CLS_B;
                    end else if (class_a_q.size() != 0) begin
                        src = CLS_A;
                    end else if (class_b_q.size() != 0) begin
                        src = CLS_B;
                    end
                end
                PREF_A: begin
                    if (class_a_q.size() != 0) src = CLS_A;
                end
                PREF_B: begin
                    if (class_b_q.size() != 0) src = CLS_B;
                end
                default: ;
            endcase
            if (src == CLS_A) begin
                head = class_a_q.pop_front();
                hit = 1'b1;
                out_id = head.id;
            end else if (src == CLS_B) begin
                head = class_b_q.pop_front();
                hit = 1'b1;
                out_id = head.id;
            end
        end
    endfunction

    // Random id, biased toward the extremes, optionally forced into one class
    function automatic logic signed [31:0] pick_id(input t_cls cls);
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = 32'sd0;
            3:       v = 32'sd1;
            4:       v = -32'sd1;
            default: v = $urandom;
        endcase
        if (cls == CLS_A && v <= 0) begin
            v = {1'b0, v[30:0]};
            if (v == 0) v = 32'sd1;
        end else if (cls == CLS_B && v > 0) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [1:0] pick_pref();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return PREF_UNUSED;
        else if (r < 8) return PREF_ANY;
        else if (r < 14) return PREF_A;
        else return PREF_B;
    endfunction

    // Offer one word after a random gap; predict once the block takes it.
    task automatic offer_word(input logic op, input logic signed [31:0] id,
            input logic [1:0] pref, input t_chk chk, input logic signed [31:0] want);
        int                 gap;
        logic               hit;
        logic signed [31:0] got;
        gap = tx_fast ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 99) < 2) tx_fast = !tx_fast;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_entry_id   <= id;
        i_preference <= pref;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shelter_step(op, id, pref, hit, got);
        case (chk)
            CHK_MODEL: if (hit) removed_ids.push_back(got);
            CHK_ID:    removed_ids.push_back(want);
            default:   ;
        endcase
    endtask

    // Result checker: every accepted removal against the oldest owed id
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (removed_ids.size() == 0) begin
                $display("%0t: unexpected removal, expected none, actual removed_id %0d",
                         $time, o_removed_id);
                n_err++;
            end else begin
                want_id = removed_ids.pop_front();
                if (o_removed_id !== want_id) begin
                    $display("%0t: removed_id mismatch, expected %0d, actual %0d",
                             $time, want_id, o_removed_id);
                    n_err++;
                end
            end
        end
    end

    // Receiver: random stall before each removal word, with two long
    // hold-offs so that a pending removal blocks and the input stalls.
    initial begin : rx_side
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (n_removed == 40 || n_removed == 300) hold = HOLD_OFF;
            else hold = rx_fast ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 99) < 2) rx_fast = !rx_fast;
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
            n_removed++;
        end
    end

    initial begin : tx_side
        int   n_sent;
        int   round;
        int   ins_pct;
        int   n_words;
        t_cls fill_cls;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_INSERT;
        i_entry_id   = '0;
        i_preference = PREF_ANY;
        next_stamp   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            offer_word(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].pref,
                       DIR_ROWS[i].chk, DIR_ROWS[i].want);
        end

        // Random rounds. Round 0 fills one class past full, round 1 sends more removes
        // than a queue holds, at random preferences; later rounds mix inserts and
        // removes at a random ratio, with an occasional fill or drain burst.
        n_sent = 0;
        round = 0;
        while (n_sent < RANDOM_WORDS) begin
            if (round == 0 || (round > 1 && $urandom_range(0, 14) == 0)) begin
                fill_cls = $urandom_range(0, 1) ? CLS_A : CLS_B;
                n_words = QUEUE_DEPTH + $urandom_range(2, 12);
                repeat (n_words)
                    offer_word(OP_INSERT, pick_id(fill_cls), 2'($urandom_range(0, 3)),
                               CHK_MODEL, '0);
            end else if (round == 1 || $urandom_range(0, 7) == 0) begin
                n_words = (round == 1) ? QUEUE_DEPTH + 20 : 60;
                repeat (n_words)
                    offer_word(OP_REMOVE, $urandom, pick_pref(), CHK_MODEL, '0);
            end else begin
                n_words = 40;
                ins_pct = $urandom_range(30, 70);
                repeat (n_words) begin
                    if ($urandom_range(0, 99) < ins_pct)
                        offer_word(OP_INSERT, pick_id(CLS_NONE), 2'($urandom_range(0, 3)),
                                   CHK_MODEL, '0);
                    else
                        offer_word(OP_REMOVE, $urandom, pick_pref(), CHK_MODEL, '0);
                end
            end
            n_sent += n_words;
            round++;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for every owed removal, then a settle time for strays
        while (removed_ids.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WORDS) @(posedge i_clk);

        if (n_err == 0 && removed_ids.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
